// ===== design/shsp_pkg.sv =====
// Shared types, constants and register codes of the system header stack parser.
`default_nettype none

package shsp_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_OFFSET = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LB_KEY_EXT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STACKING_EXT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_UDH_ENABLE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UDH_BYTES     = 3'd4;

  localparam logic [7:0] HEADER_OFFSET_RESET = 8'd32;
  localparam int         MAX_UDH_BYTES_DEF   = 15;

  // Header lengths in bytes
  localparam logic [5:0] TRANSPORT_BYTES = 6'd9;
  localparam logic [5:0] LB_EXT_BYTES    = 6'd1;
  localparam logic [5:0] DSP_EXT_BYTES   = 6'd2;
  localparam logic [5:0] STACK_EXT_BYTES = 6'd2;
  localparam logic [5:0] TS_BYTES        = 6'd6;
  localparam logic [5:0] PPH_BYTES       = 6'd7;
  localparam logic [5:0] EDIT_EXT_BYTES  = 6'd3;
  localparam logic [5:0] LEARN_EXT_BYTES = 6'd5;
  localparam logic [5:0] TRAP_OAM_BYTES  = 6'd3;
  localparam logic [5:0] TRAP_MID_BYTES  = 6'd5;
  localparam logic [5:0] TRAP_LONG_BYTES = 6'd8;

  // Trap extension kinds
  localparam logic [1:0] TRAP_NONE = 2'd0;
  localparam logic [1:0] TRAP_OAM  = 2'd1;
  localparam logic [1:0] TRAP_MID  = 2'd2;
  localparam logic [1:0] TRAP_LONG = 2'd3;

  // Timestamp header type that carries OAM stamp data
  localparam logic [1:0] TS_TYPE_OAM = 2'd0;

  // Result status
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_TRUNC = 1'b1;

  typedef struct packed {
    logic [7:0] header_offset;
    logic       lb_key_ext_enable;
    logic       stacking_ext_enable;
    logic       udh_enable;
    logic [3:0] udh_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [13:0] packet_size;
    logic [15:0] src_sys_port;
    logic [7:0]  pp_dsp;
    logic [18:0] outlif;
    logic [14:0] ftmh_flags;
    logic [4:0]  otsh_info;
    logic [41:0] oam_timestamp;
    logic [9:0]  pph_info;
    logic [15:0] oam_id;
    logic [7:0]  trap_code;
    logic [5:0]  header_size;
  } result_t;

endpackage

`default_nettype wire

// ===== design/shsp_cfg_regs.sv =====
// Configuration registers of the system header stack parser.
`default_nettype none

module shsp_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [shsp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [shsp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output shsp_pkg::cfg_t                     cfg
);
  import shsp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_offset       <= HEADER_OFFSET_RESET;
      cfg.lb_key_ext_enable   <= 1'b0;
      cfg.stacking_ext_enable <= 1'b0;
      cfg.udh_enable          <= 1'b0;
      cfg.udh_bytes           <= 4'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HEADER_OFFSET: cfg.header_offset       <= cfg_data;
        CFG_LB_KEY_EXT:    cfg.lb_key_ext_enable   <= cfg_data[0];
        CFG_STACKING_EXT:  cfg.stacking_ext_enable <= cfg_data[0];
        CFG_UDH_ENABLE:    cfg.udh_enable          <= cfg_data[0];
        CFG_UDH_BYTES:     cfg.udh_bytes           <= cfg_data[3:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/shsp_parse.sv =====
// Byte position tracking, header field capture and result register.
`default_nettype none

module shsp_parse #(
  parameter int MAX_UDH_BYTES = shsp_pkg::MAX_UDH_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic               advance,
  input  shsp_pkg::in_item_t item,
  input  shsp_pkg::cfg_t     cfg,
  output logic               res_valid,
  output shsp_pkg::result_t  res
);
  import shsp_pkg::*;

  logic [8:0] byte_position;
  logic [8:0] byte_position_next;
  logic       parse_done;
  logic       parse_done_next;

  // captured header bytes, each at its computed place in the stack
  logic [7:0] base_b [0:8];
  logic [7:0] ts_b   [0:5];
  logic [7:0] pph_b  [0:1];
  logic [7:0] trap_b [0:2];

  logic [7:0] base_v [0:8];
  logic [7:0] ts_v   [0:5];
  logic [7:0] pph_v  [0:1];
  logic [7:0] trap_v [0:2];

  logic [8:0] eff_pos;
  logic       active;
  logic       in_hdr;
  logic [8:0] idx;
  logic [9:0] n;
  logic       has_ts;
  logic       has_pph;
  logic [1:0] kind;
  logic [5:0] udh_len;
  logic [5:0] trap_len;
  logic [5:0] pos_ts;
  logic [5:0] pos_pph;
  logic [5:0] pos_trap;
  logic [5:0] end_pos;
  logic       complete;
  logic       emit;
  result_t    res_next;

  always_comb begin
    eff_pos = item.first_byte ? 9'd0 : byte_position;
    active  = item.first_byte || !parse_done;
    in_hdr  = eff_pos >= {1'b0, cfg.header_offset};
    idx     = eff_pos - {1'b0, cfg.header_offset};
    n       = {1'b0, idx} + 10'd1;

    for (int k = 0; k < 9; k++) begin
      base_v[k] = (in_hdr && idx == 9'(k)) ? item.data_byte : base_b[k];
    end

    has_ts  = base_v[5][2];
    has_pph = base_v[5][1];

    pos_ts = TRANSPORT_BYTES
           + (cfg.lb_key_ext_enable   ? LB_EXT_BYTES    : 6'd0)
           + (base_v[8][3]            ? DSP_EXT_BYTES   : 6'd0)
           + (cfg.stacking_ext_enable ? STACK_EXT_BYTES : 6'd0);
    pos_pph  = pos_ts + (has_ts ? TS_BYTES : 6'd0);
    pos_trap = pos_pph + PPH_BYTES;

    for (int k = 0; k < 6; k++) begin
      ts_v[k] = (in_hdr && idx == {3'b0, pos_ts + 6'(k)}) ? item.data_byte : ts_b[k];
    end
    for (int k = 0; k < 2; k++) begin
      pph_v[k] = (in_hdr && idx == {3'b0, pos_pph + 6'(k)}) ? item.data_byte : pph_b[k];
    end
    for (int k = 0; k < 3; k++) begin
      trap_v[k] = (in_hdr && idx == {3'b0, pos_trap + 6'(k)}) ? item.data_byte : trap_b[k];
    end

    kind = pph_v[0][5:4];
    case (kind)
      TRAP_OAM:  trap_len = TRAP_OAM_BYTES;
      TRAP_MID:  trap_len = TRAP_MID_BYTES;
      TRAP_LONG: trap_len = TRAP_LONG_BYTES;
      default:   trap_len = 6'd0;
    endcase

    udh_len = ({2'b0, cfg.udh_bytes} > 6'(MAX_UDH_BYTES)) ? 6'(MAX_UDH_BYTES)
                                                         : {2'b0, cfg.udh_bytes};

    if (has_pph) begin
      end_pos = pos_trap + trap_len
              + (pph_v[0][7]    ? EDIT_EXT_BYTES  : 6'd0)
              + (pph_v[0][6]    ? LEARN_EXT_BYTES : 6'd0)
              + (cfg.udh_enable ? udh_len         : 6'd0);
    end else begin
      end_pos = pos_pph;
    end

    // every stack is at least the transport header long, so n covers bytes 5 and 8
    complete = in_hdr && n == {4'b0, end_pos};
    emit     = take && active && (complete || item.last_byte);

    res_next = '0;
    if (complete) begin
      res_next.status       = STATUS_OK;
      res_next.packet_size  = {base_v[0], base_v[1][7:2]};
      res_next.src_sys_port = {base_v[2][6:0], base_v[3], base_v[4][7]};
      res_next.pp_dsp       = {base_v[4][6:0], base_v[5][7]};
      res_next.outlif       = {base_v[6][6:0], base_v[7], base_v[8][7:4]};
      res_next.ftmh_flags   = {base_v[1][1:0], base_v[2][7], base_v[5][6:0],
                               base_v[6][7], base_v[8][3:0]};
      if (has_ts && ts_v[0][7:6] == TS_TYPE_OAM) begin
        res_next.otsh_info     = {1'b1, ts_v[0][5:3], ts_v[0][2]};
        res_next.oam_timestamp = {ts_v[0][1:0], ts_v[1], ts_v[2], ts_v[3], ts_v[4], ts_v[5]};
      end
      if (has_pph) begin
        res_next.pph_info = {1'b1, kind, pph_v[1][7:1]};
        if (kind == TRAP_OAM) begin
          res_next.oam_id    = {trap_v[0], trap_v[1]};
          res_next.trap_code = trap_v[2];
        end
      end
      res_next.header_size = end_pos;
    end else begin
      res_next.status = STATUS_TRUNC;
    end

    byte_position_next = (eff_pos == 9'h1FF) ? eff_pos : eff_pos + 9'd1;
    parse_done_next    = complete || item.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 9'd0;
      parse_done    <= 1'b1;
    end else if (take && active) begin
      byte_position <= byte_position_next;
      parse_done    <= parse_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && active) begin
      for (int k = 0; k < 9; k++) base_b[k] <= base_v[k];
      for (int k = 0; k < 6; k++) ts_b[k]   <= ts_v[k];
      for (int k = 0; k < 2; k++) pph_b[k]  <= pph_v[k];
      for (int k = 0; k < 3; k++) trap_b[k] <= trap_v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/system_header_stack_parser.sv =====
// Top level of the system header stack parser: input stage, config and parse core.
// An accepted byte is registered in the input register, then its result (if any) in the result register.
// Throughput: one byte per cycle; the input register and the result register
// advance together and only hold while a finished result waits under out_stall.
// Reset (rst, synchronous, active high): config returns to its reset values, the
// parser waits for a first byte, and both stages empty.
`default_nettype none

module system_header_stack_parser #(
  parameter int MAX_UDH_BYTES = shsp_pkg::MAX_UDH_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input byte channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  shsp_pkg::in_item_t                in_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output shsp_pkg::result_t                 out_data,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [shsp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [shsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import shsp_pkg::*;

  cfg_t     cfg;
  logic     stage_valid;
  in_item_t stage_item;
  logic     advance;
  logic     take;

  // The whole pipe moves unless a finished result is held by the consumer.
  assign advance  = !(out_valid && out_stall);
  assign take     = stage_valid && advance;
  // Hold the input only while the stage holds a byte that cannot move on.
  assign in_stall = stage_valid && !advance;

  shsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register: load a new transaction whenever the stage is free or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_item <= in_data;
    end
  end

  // Parse core: tracks byte position, captures header bytes at their places in
  // the stack and registers one result per completed or truncated packet.
  shsp_parse #(
    .MAX_UDH_BYTES (MAX_UDH_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .advance   (advance),
    .item      (stage_item),
    .cfg       (cfg),
    .res_valid (out_valid),
    .res       (out_data)
  );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the system header stack parser, with its own byte-level predictor.
`timescale 1ns / 1ps

module tb_top;
  import shsp_pkg::*;

  // Stacks never exceed 58 bytes, so the capture store needs no more than this
  localparam int STORE_DEPTH     = 64;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int ITEM_TARGET     = 650;
  localparam int RESULT_TARGET   = 40;
  localparam int SETTLE_CYCLES   = 6;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum int {SHAPE_COMPLETE, SHAPE_TRUNC, SHAPE_RESTART} pkt_shape_e;

  // One line of the directed table; fixed rows carry a hand-written expectation
  typedef struct {
    in_item_t item;
    bit       fixed;
    bit       fixed_hit;
    result_t  fixed_res;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  in_item_t in_data;
  logic     out_valid;
  logic     out_stall;
  result_t  out_data;
  logic     cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Hand-written expectation that travels with the byte being offered
  logic    row_fixed;
  logic    row_hit;
  result_t row_res;

  // Predictor state: a shadow of the registers and of the parse progress
  cfg_t       shadow_cfg;
  logic [8:0] byte_pos;
  logic       waiting_first;
  logic [5:0] known_stack_len;
  logic [7:0] captured_bytes [STORE_DEPTH];

  result_t pending_headers [$];
  int      errors = 0;
  int      results_predicted = 0;
  int      counted_items = 0;
  int      sender_idle_pct = 0;
  int      stall_pct = 0;
  int      hold_asks = 0;
  int      hold_taken = 0;
  int      hold_left = 0;

  system_header_stack_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Total stack length from the first n captured bytes; 0 while it cannot be known yet.
  function automatic int stack_length(int n);
    int         len;
    logic [7:0] pph0;
    if (n < int'(TRANSPORT_BYTES)) return 0;
    len = TRANSPORT_BYTES;
    if (shadow_cfg.lb_key_ext_enable) len += LB_EXT_BYTES;
    if (captured_bytes[8][3]) len += DSP_EXT_BYTES;
    if (shadow_cfg.stacking_ext_enable) len += STACK_EXT_BYTES;
    // Timestamp header: present on internal type bit 1
    if (captured_bytes[5][2]) begin
      if (n <= len) return 0;
      len += TS_BYTES;
    end
    // Internal header: its first byte decides the extensions behind it
    if (captured_bytes[5][1]) begin
      if (n <= len) return 0;
      pph0 = captured_bytes[len];
      len += PPH_BYTES;
      case (pph0[5:4])
        TRAP_OAM:  len += TRAP_OAM_BYTES;
        TRAP_MID:  len += TRAP_MID_BYTES;
        TRAP_LONG: len += TRAP_LONG_BYTES;
        default:   ;
      endcase
      if (pph0[7]) len += EDIT_EXT_BYTES;
      if (pph0[6]) len += LEARN_EXT_BYTES;
      if (shadow_cfg.udh_enable)
        len += (shadow_cfg.udh_bytes > MAX_UDH_BYTES_DEF) ? MAX_UDH_BYTES_DEF
                                                          : shadow_cfg.udh_bytes;
    end
    return len;
  endfunction

  // Decode a complete stack of the given length into its result fields.
  function automatic result_t decode_header_stack(int len);
    result_t    r;
    int         at;
    logic [1:0] ftype;
    logic [1:0] kind;
    logic [7:0] ts0;
    logic [7:0] pph0;
    r = '0;
    ftype          = captured_bytes[5][2:1];
    r.status       = STATUS_OK;
    r.packet_size  = {captured_bytes[0], captured_bytes[1][7:2]};
    r.src_sys_port = {captured_bytes[2][6:0], captured_bytes[3], captured_bytes[4][7]};
    r.pp_dsp       = {captured_bytes[4][6:0], captured_bytes[5][7]};
    r.outlif       = {captured_bytes[6][6:0], captured_bytes[7], captured_bytes[8][7:4]};
    // tc, dp, action, type, mirror, mc, then the four low flag bits of byte 8
    r.ftmh_flags   = {captured_bytes[1][1:0], captured_bytes[2][7], captured_bytes[5][6:5],
                      captured_bytes[5][4:3], ftype, captured_bytes[5][0],
                      captured_bytes[6][7], captured_bytes[8][3:0]};
    at = TRANSPORT_BYTES;
    if (shadow_cfg.lb_key_ext_enable) at += LB_EXT_BYTES;
    if (captured_bytes[8][3]) at += DSP_EXT_BYTES;
    if (shadow_cfg.stacking_ext_enable) at += STACK_EXT_BYTES;
    if (ftype[1]) begin
      ts0 = captured_bytes[at];
      // Report the stamp only for the OAM timestamp type
      if (ts0[7:6] == TS_TYPE_OAM) begin
        r.otsh_info     = {1'b1, ts0[5:3], ts0[2]};
        r.oam_timestamp = {ts0[1:0], captured_bytes[at+1], captured_bytes[at+2],
                           captured_bytes[at+3], captured_bytes[at+4], captured_bytes[at+5]};
      end
      at += TS_BYTES;
    end
    if (ftype[0]) begin
      pph0       = captured_bytes[at];
      kind       = pph0[5:4];
      r.pph_info = {1'b1, kind, captured_bytes[at+1][7:1]};
      at += PPH_BYTES;
      if (kind == TRAP_OAM) begin
        r.oam_id    = {captured_bytes[at], captured_bytes[at+1]};
        r.trap_code = captured_bytes[at+2];
      end
    end
    r.header_size = len[5:0];
    return r;
  endfunction

  // Advance the predictor by one accepted byte; return 1 when a result is due.
  function automatic bit parse_header_byte(input in_item_t it, output result_t r);
    int n;
    int len;
    r = '0;
    if (it.first_byte) begin
      byte_pos        = '0;
      waiting_first   = 1'b0;
      known_stack_len = '0;
    end
    if (waiting_first) return 1'b0;
    if (byte_pos >= shadow_cfg.header_offset) begin
      n = int'(byte_pos) - int'(shadow_cfg.header_offset);
      if (n < STORE_DEPTH) captured_bytes[n] = it.data_byte;
      n++;
      len = stack_length(n);
      known_stack_len = len[5:0];
      if (len != 0 && n == len) begin
        r = decode_header_stack(len);
        waiting_first = 1'b1;
        return 1'b1;
      end
    end
    if (byte_pos != 9'd511) byte_pos++;
    if (it.last_byte) begin
      r.status      = STATUS_TRUNC;
      waiting_first = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("%0t mismatch %s: expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  task automatic check_result(input result_t want, input result_t got);
    check_field("status", want.status, got.status);
    check_field("packet_size", want.packet_size, got.packet_size);
    check_field("src_sys_port", want.src_sys_port, got.src_sys_port);
    check_field("pp_dsp", want.pp_dsp, got.pp_dsp);
    check_field("outlif", want.outlif, got.outlif);
    check_field("ftmh_flags", want.ftmh_flags, got.ftmh_flags);
    check_field("otsh_info", want.otsh_info, got.otsh_info);
    check_field("oam_timestamp", want.oam_timestamp, got.oam_timestamp);
    check_field("pph_info", want.pph_info, got.pph_info);
    check_field("oam_id", want.oam_id, got.oam_id);
    check_field("trap_code", want.trap_code, got.trap_code);
    check_field("header_size", want.header_size, got.header_size);
  endtask

  // Score results first, then predict from the byte taken at this edge.
  // Both read pre-edge values, so the order against the block does not matter.
  always @(posedge clk) begin
    result_t want;
    bit      hit;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_headers.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t unexpected result: %p", $realtime, out_data);
        end else begin
          check_result(pending_headers.pop_front(), out_data);
        end
      end
      if (in_valid && !in_stall) begin
        hit = parse_header_byte(in_data, want);
        if (row_fixed) begin
          hit  = row_hit;
          want = row_res;
        end
        if (hit) begin
          pending_headers.push_back(want);
          results_predicted++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the sequence asks for one
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asks) begin
      hold_taken <= hold_asks;
      hold_left  <= HOLD_OFF_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Offer one byte and hold it until the block takes it.
  task automatic offer_byte(input in_item_t it, input bit fixed, input bit fixed_hit,
                            input result_t fixed_res);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= it;
    row_fixed <= fixed;
    row_hit   <= fixed_hit;
    row_res   <= fixed_res;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers back to back; only called while the block is idle.
  task automatic apply_settings(input cfg_t c);
    logic [CFG_DATA_W-1:0] vals [5];
    logic [CFG_INDEX_W-1:0] idxs [5];
    idxs = '{CFG_HEADER_OFFSET, CFG_LB_KEY_EXT, CFG_STACKING_EXT, CFG_UDH_ENABLE,
             CFG_UDH_BYTES};
    vals = '{c.header_offset, CFG_DATA_W'(c.lb_key_ext_enable),
             CFG_DATA_W'(c.stacking_ext_enable), CFG_DATA_W'(c.udh_enable),
             CFG_DATA_W'(c.udh_bytes)};
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en  <= 1'b0;
    shadow_cfg = c;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 69; stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  stall_pct = 69; end
      default:       begin sender_idle_pct = 38; stall_pct = 38; end
    endcase
  endtask

  // Build one packet with a well-formed stack and random content, then send it
  // whole, cut short by an early last byte, or cut short by the next packet.
  task automatic send_packet(input pkt_shape_e shape);
    logic [7:0] pkt [$];
    logic [7:0] b;
    logic [1:0] ftype;
    logic       dsp;
    int         stack_stop;
    int         len;
    in_item_t   it;
    ftype = $urandom_range(3, 0);
    dsp   = $urandom_range(1, 0);
    repeat (shadow_cfg.header_offset) pkt.push_back($urandom_range(255, 0));
    for (int i = 0; i < TRANSPORT_BYTES; i++) begin
      b = $urandom_range(255, 0);
      if (i == 5) b[2:1] = ftype;
      if (i == 8) b[3] = dsp;
      pkt.push_back(b);
    end
    repeat ((shadow_cfg.lb_key_ext_enable ? LB_EXT_BYTES : 0) +
            (dsp ? DSP_EXT_BYTES : 0) +
            (shadow_cfg.stacking_ext_enable ? STACK_EXT_BYTES : 0))
      pkt.push_back($urandom_range(255, 0));
    if (ftype[1]) begin
      b = $urandom_range(255, 0);
      // Favor the OAM stamp type so the stamp fields get exercised
      if ($urandom_range(1, 0)) b[7:6] = TS_TYPE_OAM;
      pkt.push_back(b);
      repeat (TS_BYTES - 1) pkt.push_back($urandom_range(255, 0));
    end
    if (ftype[0]) begin
      b = $urandom_range(255, 0);
      pkt.push_back(b);
      repeat (PPH_BYTES - 1) pkt.push_back($urandom_range(255, 0));
      case (b[5:4])
        TRAP_OAM:  repeat (TRAP_OAM_BYTES) pkt.push_back($urandom_range(255, 0));
        TRAP_MID:  repeat (TRAP_MID_BYTES) pkt.push_back($urandom_range(255, 0));
        TRAP_LONG: repeat (TRAP_LONG_BYTES) pkt.push_back($urandom_range(255, 0));
        default:   ;
      endcase
      if (b[7]) repeat (EDIT_EXT_BYTES) pkt.push_back($urandom_range(255, 0));
      if (b[6]) repeat (LEARN_EXT_BYTES) pkt.push_back($urandom_range(255, 0));
      if (shadow_cfg.udh_enable)
        repeat (shadow_cfg.udh_bytes) pkt.push_back($urandom_range(255, 0));
    end
    stack_stop = pkt.size();
    if (shape == SHAPE_COMPLETE) begin
      // Zero trailing bytes puts the last-byte mark on the stack's final byte
      repeat ($urandom_range(3, 0)) pkt.push_back($urandom_range(255, 0));
      len = pkt.size();
      counted_items += stack_stop;
    end else begin
      len = $urandom_range(stack_stop - 1, 1);
      counted_items += len;
    end
    for (int i = 0; i < len; i++) begin
      it.data_byte  = pkt[i];
      it.first_byte = (i == 0);
      it.last_byte  = (shape != SHAPE_RESTART) && (i == len - 1);
      offer_byte(it, 1'b0, 1'b0, '0);
    end
  endtask

  initial begin
    stim_row_t  directed_rows [$];
    stim_row_t  row;
    result_t    trunc_res;
    result_t    bare_transport_res;
    cfg_t       c;
    logic [7:0] ones_header [9];
    pkt_shape_e shape;
    in_item_t   noise;
    int         phase;
    int         packets;
    int         pick;

    // Drive every input and the predictor state before the first edge
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    row_fixed     = 1'b0;
    row_hit       = 1'b0;
    row_res       = '0;
    byte_pos      = '0;
    waiting_first = 1'b1;
    known_stack_len = '0;
    for (int i = 0; i < STORE_DEPTH; i++) captured_bytes[i] = '0;
    shadow_cfg    = '{header_offset: HEADER_OFFSET_RESET, default: '0};

    trunc_res                      = '0;
    trunc_res.status               = STATUS_TRUNC;
    bare_transport_res             = '0;
    bare_transport_res.header_size = TRANSPORT_BYTES;
    // Transport header of all ones except type 0 and no destination extension
    ones_header = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hF9, 8'hFF, 8'hFF, 8'hF7};

    // Directed table, parsed from byte 0 of the packet:
    //   a stray byte while idle is ignored,
    //   an early last byte truncates, also on a one-byte packet,
    //   a new first byte drops the packet in progress,
    //   a stack that completes on the last byte is reported complete.
    directed_rows.push_back('{'{8'hA5, 1'b0, 1'b1}, 1'b1, 1'b0, '0});
    directed_rows.push_back('{'{8'hFF, 1'b1, 1'b0}, 1'b0, 1'b0, '0});
    directed_rows.push_back('{'{8'h00, 1'b0, 1'b1}, 1'b1, 1'b1, trunc_res});
    directed_rows.push_back('{'{8'h7E, 1'b1, 1'b1}, 1'b1, 1'b1, trunc_res});
    directed_rows.push_back('{'{8'hFF, 1'b1, 1'b0}, 1'b0, 1'b0, '0});
    for (int i = 0; i < TRANSPORT_BYTES; i++) begin
      row.item      = '{8'h00, i == 0, i == TRANSPORT_BYTES - 1};
      row.fixed     = 1'b1;
      row.fixed_hit = (i == TRANSPORT_BYTES - 1);
      row.fixed_res = row.fixed_hit ? bare_transport_res : '0;
      directed_rows.push_back(row);
    end
    for (int i = 0; i < TRANSPORT_BYTES; i++)
      directed_rows.push_back('{'{ones_header[i], i == 0, i == TRANSPORT_BYTES - 1},
                                1'b0, 1'b0, '0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(IDLE_NONE);
    apply_settings('{header_offset: 8'd0, default: '0});
    foreach (directed_rows[i])
      offer_byte(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].fixed_hit,
                 directed_rows[i].fixed_res);
    drain();

    // Random phases: fixed settings first (extremes), then the reset header offset with random fields, then random ones
    phase = 0;
    while (phase < 6 || counted_items < ITEM_TARGET || results_predicted < RESULT_TARGET) begin
      packets = 6;
      case (phase)
        0: c = '{8'd0,   1'b0, 1'b0, 1'b0, 4'd0};
        1: c = '{8'd3,   1'b1, 1'b1, 1'b1, 4'd15};
        2: begin
          c = '{8'd255, 1'b1, 1'b0, 1'b1, 4'd7};
          packets = 2;
        end
        3: c = '{8'd1,   1'b0, 1'b1, 1'b1, 4'd0};
        4: c = '{8'd0,   1'b0, 1'b0, 1'b0, 4'd0};
        5: c = '{HEADER_OFFSET_RESET, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                 1'b1, 4'($urandom_range(15, 0))};
        default: c = '{8'($urandom_range(7, 0)), 1'($urandom_range(1, 0)),
                       1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                       4'($urandom_range(15, 0))};
      endcase
      apply_settings(c);
      set_idling(idle_mode_e'(phase % 4));
      // Hold off the receiver while packets stream in, so results back up
      if (phase == 4) hold_asks++;
      for (int p = 0; p < packets; p++) begin
        pick = $urandom_range(99, 0);
        if (pick < 70) shape = SHAPE_COMPLETE;
        else if (pick < 85 || p == packets - 1) shape = SHAPE_TRUNC;
        else shape = SHAPE_RESTART;
        // End each phase on a terminated packet so the block is idle for the next writes
        if (p == packets - 1 && pick < 70) shape = SHAPE_COMPLETE;
        send_packet(shape);
        if ($urandom_range(3, 0) == 0) begin
          repeat ($urandom_range(3, 1)) begin
            noise.data_byte  = $urandom_range(255, 0);
            noise.first_byte = 1'b0;
            noise.last_byte  = $urandom_range(1, 0);
            offer_byte(noise, 1'b0, 1'b0, '0);
          end
        end
      end
      drain();
      phase++;
    end

    errors += pending_headers.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
